// ===== hdl/rsd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and constants
// Item formats, operation codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package rsd_pkg;

  localparam int TEXT_DEPTH    = 64;
  localparam int PATTERN_DEPTH = 16;

  localparam int TEXT_AW = $clog2(TEXT_DEPTH);
  localparam int PAT_AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int TLEN_W  = $clog2(TEXT_DEPTH + 1);
  localparam int PLEN_W  = $clog2(PATTERN_DEPTH + 1);
  localparam int SUM_W   = ((TLEN_W > PLEN_W) ? TLEN_W : PLEN_W) + 1;

  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_PAT  = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;

  localparam logic [6:0] CUT_MAX = 7'd64;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_in;
  } rsd_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       is_last;
    logic       is_empty;
    logic       overflow;
    logic [6:0] cut_count;
  } rsd_out_t;

  typedef struct packed {
    logic load_text;
    logic load_pat;
    logic run_init;
    logic rd_cmp;
    logic cmp_adv;
    logic mv_rd;
    logic mv_wr;
    logic mv_fin;
    logic em_init;
    logic em_rd;
    logic em_ld;
    logic em_empty;
    logic clear;
  } rsd_ctl_t;

  typedef struct packed {
    logic no_search;
    logic match_eq;
    logic k_last;
    logic no_more;
    logic mv_end;
    logic tlen_zero;
    logic em_last;
    logic out_free;
  } rsd_stat_t;

endpackage

// ===== hdl/rsd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsd_ctrl: sequencing state machine
// Takes items, then steps search, cut and emit phases of a run.
// ---------------------------------------------------------------------------
module rsd_ctrl
  import rsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] operation,
  output logic       req_stall,
  input  rsd_stat_t  stat,
  output rsd_ctl_t   ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_CMP      = 4'd3;
  localparam logic [3:0] S_MV_RD    = 4'd4;
  localparam logic [3:0] S_MV_WR    = 4'd5;
  localparam logic [3:0] S_EM_INIT  = 4'd6;
  localparam logic [3:0] S_EM_RD    = 4'd7;
  localparam logic [3:0] S_EM_LD    = 4'd8;
  localparam logic [3:0] S_EM_EMPTY = 4'd9;

  logic [3:0] state, state_next;
  logic       accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.load_text = (operation == OP_TEXT);
          ctl.load_pat  = (operation == OP_PAT);
          ctl.run_init  = (operation == OP_RUN);
          if (operation == OP_RUN) state_next = S_START;
        end
      end
      S_START: begin
        state_next = stat.no_search ? S_EM_INIT : S_RD;
      end
      S_RD: begin
        ctl.rd_cmp = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        ctl.cmp_adv = 1'b1;
        if (stat.match_eq && stat.k_last) state_next = S_MV_RD;
        else if (stat.match_eq)           state_next = S_RD;
        else if (stat.no_more)            state_next = S_EM_INIT;
        else                              state_next = S_RD;
      end
      S_MV_RD: begin
        if (stat.mv_end) begin
          ctl.mv_fin = 1'b1;
          state_next = S_START;
        end else begin
          ctl.mv_rd  = 1'b1;
          state_next = S_MV_WR;
        end
      end
      S_MV_WR: begin
        ctl.mv_wr  = 1'b1;
        state_next = S_MV_RD;
      end
      S_EM_INIT: begin
        ctl.em_init = 1'b1;
        state_next  = stat.tlen_zero ? S_EM_EMPTY : S_EM_RD;
      end
      S_EM_RD: begin
        ctl.em_rd  = 1'b1;
        state_next = S_EM_LD;
      end
      S_EM_LD: begin
        if (stat.out_free) begin
          ctl.em_ld = 1'b1;
          if (stat.em_last) begin
            ctl.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_EM_RD;
          end
        end
      end
      S_EM_EMPTY: begin
        if (stat.out_free) begin
          ctl.em_empty = 1'b1;
          ctl.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (state == S_IDLE))
    else $error("run did not return to idle after clear");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MV_WR) |-> $past(ctl.mv_rd))
    else $error("move write without preceding read");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.em_ld || ctl.em_empty) |-> stat.out_free)
    else $error("result loaded while output register busy");

endmodule

// ===== hdl/rsd_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsd_dp: text and pattern stores, search/cut counters, result register
// Executes controller commands one step per cycle.
// ---------------------------------------------------------------------------
module rsd_dp
  import rsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [7:0] char_in,
  input  rsd_ctl_t  ctl,
  output rsd_stat_t stat,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsd_out_t  rsp
);

  logic [7:0] text_mem [TEXT_DEPTH];
  logic [7:0] pat_mem  [PATTERN_DEPTH];

  logic [TLEN_W-1:0] tlen;
  logic [PLEN_W-1:0] plen;
  logic              ovf;
  logic [TLEN_W-1:0] pos;
  logic [PLEN_W-1:0] k;
  logic [TLEN_W-1:0] idx;
  logic [6:0]        cuts;
  logic [7:0]        t_rdata;
  logic [7:0]        p_rdata;

  logic               t_we;
  logic [TEXT_AW-1:0] t_waddr;
  logic [7:0]         t_wdata;
  logic               t_re;
  logic [TEXT_AW-1:0] t_raddr;
  logic               text_room;
  logic               pat_room;
  sum_t               pos_k;
  sum_t               pos_p;
  sum_t               wr_back;
  sum_t               tl_minus;

  assign text_room = (tlen < TLEN_W'(TEXT_DEPTH));
  assign pat_room  = (plen < PLEN_W'(PATTERN_DEPTH));
  assign pos_k     = sum_t'(pos) + sum_t'(k);
  assign pos_p     = sum_t'(pos) + sum_t'(plen);
  assign wr_back   = sum_t'(idx) - sum_t'(plen);
  assign tl_minus  = sum_t'(tlen) - sum_t'(plen);

  assign stat.no_search = (plen == '0) || (sum_t'(plen) > sum_t'(tlen));
  assign stat.match_eq  = (t_rdata == p_rdata);
  assign stat.k_last    = (sum_t'(k) + sum_t'(1) == sum_t'(plen));
  assign stat.no_more   = (pos_p + sum_t'(1) > sum_t'(tlen));
  assign stat.mv_end    = (idx == tlen);
  assign stat.tlen_zero = (tlen == '0);
  assign stat.em_last   = (sum_t'(idx) + sum_t'(1) == sum_t'(tlen));
  assign stat.out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    t_we    = 1'b0;
    t_waddr = tlen[TEXT_AW-1:0];
    t_wdata = char_in;
    if (ctl.load_text && text_room) begin
      t_we = 1'b1;
    end else if (ctl.mv_wr) begin
      t_we    = 1'b1;
      t_waddr = wr_back[TEXT_AW-1:0];
      t_wdata = t_rdata;
    end
    t_re    = ctl.rd_cmp || ctl.mv_rd || ctl.em_rd;
    t_raddr = ctl.rd_cmp ? pos_k[TEXT_AW-1:0] : idx[TEXT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (t_we) text_mem[t_waddr] <= t_wdata;
    if (t_re) t_rdata <= text_mem[t_raddr];
    if (ctl.load_pat && pat_room) pat_mem[plen[PAT_AW-1:0]] <= char_in;
    if (ctl.rd_cmp) p_rdata <= pat_mem[k[PAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlen <= '0;
      plen <= '0;
      ovf  <= 1'b0;
    end else begin
      if (ctl.load_text) begin
        if (text_room) tlen <= tlen + TLEN_W'(1);
        else           ovf  <= 1'b1;
      end
      if (ctl.load_pat) begin
        if (pat_room) plen <= plen + PLEN_W'(1);
        else          ovf  <= 1'b1;
      end
      if (ctl.mv_fin) tlen <= tl_minus[TLEN_W-1:0];
      if (ctl.clear) begin
        tlen <= '0;
        plen <= '0;
        ovf  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.run_init) begin
      cuts <= '0;
      pos  <= '0;
      k    <= '0;
    end
    if (ctl.cmp_adv) begin
      if (stat.match_eq) begin
        if (stat.k_last) idx <= pos_p[TLEN_W-1:0];
        else             k   <= k + PLEN_W'(1);
      end else begin
        k   <= '0;
        pos <= pos + TLEN_W'(1);
      end
    end
    if (ctl.mv_wr) idx <= idx + TLEN_W'(1);
    if (ctl.mv_fin) begin
      pos <= '0;
      k   <= '0;
      if (cuts != CUT_MAX) cuts <= cuts + 7'd1;
    end
    if (ctl.em_init) idx <= '0;
    if (ctl.em_ld)   idx <= idx + TLEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.em_ld || ctl.em_empty) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.em_ld) begin
      rsp.char_out  <= t_rdata;
      rsp.is_last   <= stat.em_last;
      rsp.is_empty  <= 1'b0;
      rsp.overflow  <= ovf;
      rsp.cut_count <= cuts;
    end else if (ctl.em_empty) begin
      rsp.char_out  <= 8'd0;
      rsp.is_last   <= 1'b1;
      rsp.is_empty  <= 1'b1;
      rsp.overflow  <= ovf;
      rsp.cut_count <= cuts;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    tlen <= TLEN_W'(TEXT_DEPTH) && plen <= PLEN_W'(PATTERN_DEPTH))
    else $error("store length beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (tlen == '0 && plen == '0 && !ovf))
    else $error("stores not cleared after run");

  assert property (@(posedge clk) disable iff (rst)
    ctl.mv_rd |-> (idx < tlen && sum_t'(idx) >= sum_t'(plen)))
    else $error("move source out of range");

endmodule

// ===== hdl/repeated_substring_delete.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repeated_substring_delete: remove every pattern occurrence from a text
// Load items append to text/pattern stores; a run item cuts matches and
// emits the remaining text.
// ---------------------------------------------------------------------------
// Load items are accepted back to back. A run compares bytes of the leftmost
// search (restarted after each cut) in read and compare states, moves each
// byte of a cut in read and write states, emits each byte in read and load
// states, all on the single text memory port; req_stall is high throughout.
// Reset clears lengths, overflow flag and output valid; no clearing pass.
module repeated_substring_delete
  import rsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  rsd_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsd_out_t rsp
);

  rsd_ctl_t  ctl;
  rsd_stat_t stat;

  rsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .operation (req.operation),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  rsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_in   (req.char_in),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for repeated_substring_delete
// Loads text and pattern bytes, runs deletions and checks every emitted byte
// against a predictor of the cut-and-restart search, over several idling
// phases, a long receiver hold-off and stores filled beyond their depth.
// ---------------------------------------------------------------------------
module testbench;
  import rsd_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASE_ITEMS     = 4;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  rsd_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  rsd_out_t rsp;

  rsd_in_t  req_items[$];
  rsd_out_t text_expected[$];
  int       sent_items;
  int       mismatches;
  int       send_idle_pct;
  int       stall_pct;
  int       hold_seq;
  int       hold_seen;
  int       hold_left;

  // predictor state
  logic [7:0] text_img[TEXT_DEPTH];
  logic [7:0] pat_img[PATTERN_DEPTH];
  int         text_len;
  int         pat_len;
  logic       ovf_seen;

  repeated_substring_delete u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic cut_and_emit(input rsd_in_t it);
    int pos;
    int k;
    int at;
    bit hit;
    logic [6:0] cuts;
    rsd_out_t r;
    case (it.operation)
      OP_TEXT: begin
        if (text_len < TEXT_DEPTH) begin
          text_img[text_len] = it.char_in;
          text_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_PAT: begin
        if (pat_len < PATTERN_DEPTH) begin
          pat_img[pat_len] = it.char_in;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_RUN: begin
        cuts = '0;
        hit = 1'b1;
        while (hit) begin
          hit = 1'b0;
          at = 0;
          if (pat_len != 0) begin
            for (pos = 0; pos + pat_len <= text_len && !hit; pos++) begin
              k = 0;
              while (k < pat_len && text_img[pos + k] == pat_img[k]) k++;
              if (k == pat_len) begin
                hit = 1'b1;
                at = pos;
              end
            end
          end
          if (hit) begin
            for (k = at; k + pat_len < text_len; k++) text_img[k] = text_img[k + pat_len];
            text_len -= pat_len;
            if (cuts < CUT_MAX) cuts++;
          end
        end
        r.overflow = ovf_seen;
        r.cut_count = cuts;
        if (text_len == 0) begin
          r.char_out = 8'h00;
          r.is_last = 1'b1;
          r.is_empty = 1'b1;
          text_expected.push_back(r);
        end else begin
          for (k = 0; k < text_len; k++) begin
            r.char_out = text_img[k];
            r.is_last = (k == text_len - 1);
            r.is_empty = 1'b0;
            text_expected.push_back(r);
          end
        end
        text_len = 0;
        pat_len = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input rsd_out_t want, input rsd_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected char %h last %b empty %b ovf %b cuts %0d,",
                " got char %h last %b empty %b ovf %b cuts %0d"},
               what, want.char_out, want.is_last, want.is_empty, want.overflow,
               want.cut_count, got.char_out, got.is_last, got.is_empty, got.overflow,
               got.cut_count);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) cut_and_emit(req);
      if (!req_valid || !req_stall) begin
        if (req_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= req_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_seq != hold_seen) || (hold_left > 1) ||
                   ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : check
    rsd_out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (text_expected.size() == 0) begin
        flag_mismatch("unexpected", '0, rsp);
      end else begin
        want = text_expected.pop_front();
        if (rsp.char_out !== want.char_out || rsp.is_last !== want.is_last ||
            rsp.is_empty !== want.is_empty || rsp.overflow !== want.overflow ||
            rsp.cut_count !== want.cut_count)
          flag_mismatch("field", want, rsp);
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] ch);
    rsd_in_t it;
    it.operation = op;
    it.char_in = ch;
    req_items.push_back(it);
    if (op != OP_NONE) sent_items++;
  endtask

  task automatic drain();
    while (req_items.size() != 0 || req_valid || text_expected.size() != 0) @(negedge clk);
  endtask

  // one text/pattern set and its run; mostly well formed, some noise
  task automatic random_run();
    logic [7:0] base;
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int n;
    int pick;
    int at;
    int ti;
    int pi;
    base = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send(2'($urandom), 8'($urandom));
      return;
    end
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
    repeat (n) pat.push_back(base ^ 8'($urandom_range(1)));
    pick = $urandom_range(2);
    n = $urandom_range(0, 12);
    if (pick == 0) begin
      // copies nested inside each other: cuts expose new matches
      txt = pat;
      repeat ($urandom_range(1, 3)) begin
        at = $urandom_range(txt.size());
        foreach (pat[j]) txt.insert(at + j, pat[j]);
      end
    end else begin
      while (txt.size() < n) begin
        if (pick == 1 && pat.size() != 0 && $urandom_range(1))
          foreach (pat[j]) txt.push_back(pat[j]);
        else if ($urandom_range(7) == 0)
          txt.push_back(8'($urandom));
        else
          txt.push_back(base ^ 8'($urandom_range(1)));
      end
    end
    ti = 0;
    pi = 0;
    while (ti < txt.size() || pi < pat.size()) begin
      if (pi >= pat.size() || (ti < txt.size() && $urandom_range(1))) begin
        send(OP_TEXT, txt[ti]);
        ti++;
      end else begin
        send(OP_PAT, pat[pi]);
        pi++;
      end
      if ($urandom_range(19) == 0) send(OP_NONE, 8'($urandom));
    end
    send(OP_RUN, 8'($urandom));
  endtask

  // stores loaded past their depth
  task automatic flood(input bit by_pattern);
    logic [7:0] base;
    base = 8'($urandom);
    if (!by_pattern) begin
      repeat (TEXT_DEPTH + 2) send(OP_TEXT, base);
      send(OP_PAT, base);
    end else begin
      repeat (2) send(OP_TEXT, 8'($urandom));
      repeat (PATTERN_DEPTH + 1) send(OP_PAT, base);
    end
    send(OP_RUN, 8'($urandom));
  endtask

  initial begin
    int phase_end;
    text_len = 0;
    pat_len = 0;
    ovf_seen = 1'b0;
    sent_items = 0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_seq = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    send(OP_RUN, 8'h5A);
    send(OP_TEXT, 8'h00);
    send(OP_TEXT, 8'hFF);
    send(OP_NONE, 8'hFF);
    send(OP_TEXT, 8'h00);
    send(OP_RUN, 8'h00);
    send(OP_TEXT, 8'h41);
    send(OP_TEXT, 8'h42);
    send(OP_PAT, 8'h41);
    send(OP_PAT, 8'h42);
    send(OP_PAT, 8'h43);
    send(OP_RUN, 8'hFF);
    send(OP_TEXT, 8'h61);
    send(OP_TEXT, 8'h61);
    send(OP_TEXT, 8'h62);
    send(OP_TEXT, 8'h62);
    send(OP_PAT, 8'h61);
    send(OP_PAT, 8'h62);
    send(OP_RUN, 8'h00);
    send(OP_TEXT, 8'h80);
    send(OP_TEXT, 8'h7F);
    send(OP_TEXT, 8'h80);
    send(OP_PAT, 8'h7F);
    send(OP_RUN, 8'h00);
    drain();

    // no idling, with a long receiver hold-off on a long text
    phase_end = sent_items + PHASE_ITEMS;
    repeat (12) send(OP_TEXT, 8'($urandom));
    send(OP_PAT, 8'($urandom));
    send(OP_RUN, 8'($urandom));
    hold_seq++;
    while (sent_items < phase_end + 14) random_run();
    drain();

    send_idle_pct = 47;
    phase_end = sent_items + PHASE_ITEMS;
    while (sent_items < phase_end) random_run();
    drain();

    send_idle_pct = 0;
    stall_pct = 47;
    flood(1'b0);
    phase_end = sent_items + PHASE_ITEMS;
    while (sent_items < phase_end) random_run();
    drain();

    send_idle_pct = 35;
    stall_pct = 35;
    flood(1'b1);
    phase_end = sent_items + PHASE_ITEMS;
    while (sent_items < phase_end) random_run();
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && text_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
